// File: rtl/wspf_pkg.sv
// package of types, constants and helpers for the wheel speed pid core
package wspf_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_ILIM = 3'd3,
    REG_FALL = 3'd4
  } reg_idx_e;

  localparam logic [15:0] KpReset   = 16'd1331;
  localparam logic [15:0] KiReset   = 16'd333;
  localparam logic [15:0] KdReset   = 16'd0;
  localparam logic [14:0] IlimReset = 15'd960;
  localparam logic [14:0] FallReset = 15'd15360;

  // accumulator width for the serial multiply-add
  localparam int unsigned AccW = 64;
  // multiplier operand width for the bit-serial unit
  localparam int unsigned OpW = 40;
  localparam int unsigned CntW = $clog2(OpW + 1);

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] rpm_left;
    logic signed [15:0] rpm_right;
    logic signed [15:0] target_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive_value;
    logic               fallen;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_FDIV,
    ST_ERR,
    ST_INT,
    ST_PTERM,
    ST_ITERM,
    ST_DTERM,
    ST_DDIV,
    ST_OUT
  } state_e;

endpackage

// File: rtl/wspf_serial_mac.sv
// bit-serial signed multiplier: one multiplier bit per cycle, adds into the product
module wspf_serial_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [wspf_pkg::AccW-1:0] mcand_i,
  input  logic signed [wspf_pkg::OpW-1:0]  mplier_i,
  output logic                              busy_o,
  output logic signed [wspf_pkg::AccW-1:0] prod_o
);

  logic [wspf_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [wspf_pkg::OpW-1:0]         mpl_q, mpl_d;
  logic signed [wspf_pkg::AccW-1:0] mc_q, mc_d;
  logic signed [wspf_pkg::AccW-1:0] acc_q, acc_d;
  logic                             busy_q, busy_d;

  always_comb begin
    cnt_d  = cnt_q;
    mpl_d  = mpl_q;
    mc_d   = mc_q;
    acc_d  = acc_q;
    busy_d = busy_q;
    if (start_i) begin
      cnt_d  = '0;
      mpl_d  = mplier_i;
      mc_d   = mcand_i;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // top bit of a two's complement multiplier carries negative weight
      if (mpl_q[0]) begin
        if (cnt_q == wspf_pkg::CntW'(wspf_pkg::OpW - 1)) acc_d = acc_q - mc_q;
        else acc_d = acc_q + mc_q;
      end
      mc_d  = mc_q <<< 1;
      mpl_d = mpl_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == wspf_pkg::CntW'(wspf_pkg::OpW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mpl_q <= mpl_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/wspf_serial_div.sv
// restoring divider of a magnitude by a constant-width divisor, one quotient bit per cycle
module wspf_serial_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [wspf_pkg::AccW-1:0]       num_i,
  input  logic [15:0]                     den_i,
  output logic                            busy_o,
  output logic [wspf_pkg::AccW-1:0]       quo_o
);

  localparam int unsigned DCntW = $clog2(wspf_pkg::AccW + 1);

  logic [DCntW-1:0]           cnt_q, cnt_d;
  logic [wspf_pkg::AccW-1:0]  quo_q, quo_d;
  logic [16:0]                rem_q, rem_d;
  logic [15:0]                den_q, den_d;
  logic                       busy_q, busy_d;
  logic [16:0]                trial;

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    busy_d = busy_q;
    trial  = {rem_q[15:0], quo_q[wspf_pkg::AccW-1]};
    if (start_i) begin
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[wspf_pkg::AccW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[wspf_pkg::AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCntW'(wspf_pkg::AccW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/wheel_speed_pid_filtered_core.sv
// top level of the filtered wheel speed pid controller
//
// input channel in_valid_i / in_stall_o carries one sample per transaction
// (pitch, left and right wheel speed, target speed); output channel
// out_valid_o / out_stall_i returns one result per sample (drive value and
// fallen flag). gains and limits are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle.
// one sample at a time: the next sample is taken only once the current one
// has been written to the output register. the pace of a normal sample is
// set by the shared bit-serial multiplier (four products) and the bit-serial
// divider (two quotients); a fallen sample skips both. the result sits in an
// output register, so the next sample is accepted as soon as the current
// one is done and the result is either taken or parked there.
// reset restores the default gains and clears the filter, integral and
// previous error. while the receiver stalls the result holds and the block
// stalls input once it has a further result ready.
module wheel_speed_pid_filtered_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wspf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [wspf_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wspf_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wspf_pkg::out_item_t                 out_data_o
);

  localparam int unsigned AccW = wspf_pkg::AccW;
  localparam int unsigned OpW  = wspf_pkg::OpW;

  // configuration registers
  logic [15:0] kp_q, ki_q, kd_q;
  logic [14:0] ilim_q, fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= wspf_pkg::KpReset;
      ki_q   <= wspf_pkg::KiReset;
      kd_q   <= wspf_pkg::KdReset;
      ilim_q <= wspf_pkg::IlimReset;
      fall_q <= wspf_pkg::FallReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wspf_pkg::REG_KP:   kp_q   <= cfg_data_i;
        wspf_pkg::REG_KI:   ki_q   <= cfg_data_i;
        wspf_pkg::REG_KD:   kd_q   <= cfg_data_i;
        wspf_pkg::REG_ILIM: ilim_q <= cfg_data_i[14:0];
        wspf_pkg::REG_FALL: fall_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // controller state
  wspf_pkg::state_e state_q, state_d;
  logic signed [27:0] filt_q, filt_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [16:0] perr_q, perr_d;
  logic signed [16:0] err_q, err_d;
  logic signed [AccW-1:0] sum_q, sum_d;
  wspf_pkg::in_item_t in_q, in_d;
  logic neg_q, neg_d;
  // fallen flag of the transaction in flight
  logic fallen_q, fallen_d;

  // output register
  logic out_valid_q, out_valid_d;
  wspf_pkg::out_item_t out_q, out_d;

  // shared serial units
  logic mul_start, mul_busy;
  logic signed [AccW-1:0] mcand;
  logic signed [OpW-1:0]  mplier;
  logic signed [AccW-1:0] prod;
  logic div_start, div_busy;
  logic [AccW-1:0] div_num, div_quo;
  logic [15:0] div_den;
  logic started_q, started_d;

  wspf_serial_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .busy_o   (mul_busy),
    .prod_o   (prod)
  );

  wspf_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  logic accept_in, out_free;
  logic [15:0] abs_pitch;
  logic signed [AccW-1:0] avg_ext, lim_ext, integ_new, quo_signed;
  logic signed [AccW-1:0] sat_hi, sat_lo;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == wspf_pkg::ST_IDLE);
  assign accept_in = in_valid_i && !in_stall_o;

  assign abs_pitch = in_data_i.pitch_angle[15] ? 16'(-in_data_i.pitch_angle)
                                               : in_data_i.pitch_angle;
  assign avg_ext = AccW'(signed'(17'(in_q.rpm_left) + 17'(in_q.rpm_right))) <<< 11;
  assign sat_hi  = AccW'(signed'(32'h7fffffff));
  assign sat_lo  = AccW'(signed'(32'h80000000));
  // quotient carries the sign of the dividend, rounding ties away from zero
  assign quo_signed = neg_q ? -signed'(div_quo) : signed'(div_quo);

  always_comb begin
    state_d     = state_q;
    filt_d      = filt_q;
    integ_d     = integ_q;
    perr_d      = perr_q;
    err_d       = err_q;
    sum_d       = sum_q;
    in_d        = in_q;
    neg_d       = neg_q;
    fallen_d    = fallen_q;
    started_d   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mul_start   = 1'b0;
    mcand       = '0;
    mplier      = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    lim_ext     = AccW'(ilim_q) * 100;
    integ_new   = AccW'(integ_q) + AccW'(err_q);

    case (state_q)
      wspf_pkg::ST_IDLE: begin
        if (accept_in) begin
          in_d = in_data_i;
          if ({1'b0, abs_pitch} > {2'b0, fall_q}) begin
            // fallen: clear integral and history, filter untouched
            integ_d = '0;
            perr_d  = '0;
            state_d = wspf_pkg::ST_OUT;
            sum_d   = '0;
            fallen_d = 1'b1;
          end else begin
            fallen_d = 1'b0;
            state_d = wspf_pkg::ST_FILT;
          end
        end
      end
      // 7 * filter via the multiplier, then add 3 * avg
      wspf_pkg::ST_FILT: begin
        if (!started_q) begin
          mul_start = 1'b1;
          mcand  = AccW'(filt_q);
          mplier = OpW'(7);
          started_d = 1'b1;
        end else if (!mul_busy) begin
          sum_d = prod + avg_ext + (avg_ext <<< 1);
          neg_d = (prod + avg_ext + (avg_ext <<< 1)) < 0;
          state_d = wspf_pkg::ST_FDIV;
        end else started_d = 1'b1;
      end
      wspf_pkg::ST_FDIV: begin
        if (!started_q) begin
          div_start = 1'b1;
          div_num = AccW'((neg_q ? -sum_q : sum_q) + 5);
          div_den = 16'd10;
          started_d = 1'b1;
        end else if (!div_busy) begin
          filt_d  = 28'(quo_signed);
          state_d = wspf_pkg::ST_ERR;
        end else started_d = 1'b1;
      end
      // rounded shift by 4096 is exact and cheap
      wspf_pkg::ST_ERR: begin
        if (filt_q < 0)
          err_d = 17'(in_q.target_speed) +
                  17'(((-AccW'(filt_q)) + 2048) >>> 12);
        else
          err_d = 17'(in_q.target_speed) -
                  17'((AccW'(filt_q) + 2048) >>> 12);
        state_d = wspf_pkg::ST_INT;
      end
      wspf_pkg::ST_INT: begin
        if (integ_new >= lim_ext) integ_d = 32'(lim_ext);
        else integ_d = 32'(integ_new);
        if (integ_new <= -lim_ext) integ_d = 32'(-lim_ext);
        state_d = wspf_pkg::ST_PTERM;
      end
      wspf_pkg::ST_PTERM: begin
        if (!started_q) begin
          mul_start = 1'b1;
          mcand  = AccW'(err_q) * 100;
          mplier = OpW'(kp_q);
          started_d = 1'b1;
        end else if (!mul_busy) begin
          sum_d = prod;
          state_d = wspf_pkg::ST_ITERM;
        end else started_d = 1'b1;
      end
      wspf_pkg::ST_ITERM: begin
        if (!started_q) begin
          mul_start = 1'b1;
          mcand  = AccW'(integ_q);
          mplier = OpW'(ki_q);
          started_d = 1'b1;
        end else if (!mul_busy) begin
          sum_d = sum_q + prod;
          state_d = wspf_pkg::ST_DTERM;
        end else started_d = 1'b1;
      end
      wspf_pkg::ST_DTERM: begin
        if (!started_q) begin
          mul_start = 1'b1;
          mcand  = (AccW'(err_q) - AccW'(perr_q)) * 10000;
          mplier = OpW'(kd_q);
          started_d = 1'b1;
        end else if (!mul_busy) begin
          sum_d = sum_q + prod;
          neg_d = (sum_q + prod) < 0;
          perr_d = err_q;
          state_d = wspf_pkg::ST_DDIV;
        end else started_d = 1'b1;
      end
      wspf_pkg::ST_DDIV: begin
        if (!started_q) begin
          div_start = 1'b1;
          div_num = AccW'((neg_q ? -sum_q : sum_q) + 12800);
          div_den = 16'd25600;
          started_d = 1'b1;
        end else if (!div_busy) begin
          // drive is the negated quotient
          sum_d = -quo_signed;
          state_d = wspf_pkg::ST_OUT;
        end else started_d = 1'b1;
      end
      wspf_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.fallen = fallen_q;
          if (sum_q > sat_hi) out_d.drive_value = 32'h7fffffff;
          else if (sum_q < sat_lo) out_d.drive_value = 32'h80000000;
          else out_d.drive_value = 32'(sum_q);
          state_d = wspf_pkg::ST_IDLE;
        end
      end
      default: state_d = wspf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wspf_pkg::ST_IDLE;
      filt_q      <= '0;
      integ_q     <= '0;
      perr_q      <= '0;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      integ_q     <= integ_d;
      perr_q      <= perr_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    sum_q    <= sum_d;
    in_q     <= in_d;
    neg_q    <= neg_d;
    fallen_q <= fallen_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a fallen result always carries a zero drive value
  a_fallen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fallen |-> out_data_o.drive_value == 32'd0)
    else $error("fallen result with non-zero drive");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the integral never leaves its clamp
  a_integ_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wspf_pkg::ST_PTERM |->
      (AccW'(integ_q) <= lim_ext) && (AccW'(integ_q) >= -lim_ext))
    else $error("integral outside clamp");

endmodule

// File: sim/wspf_checker.sv
// transaction monitor, drive value predictor and result comparison for the pid core
`timescale 1ns / 100ps
module wspf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wspf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wspf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  wspf_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  wspf_pkg::out_item_t           out_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import wspf_pkg::*;

  longint unsigned kp_q, ki_q, kd_q, ilim_q, fall_q;
  longint          filt_q, integ_q, prev_err_q;
  out_item_t       drive_fifo[$];
  int              fails;

  assign fail_count_o = fails;
  assign pending_o    = drive_fifo.size();

  // round to nearest, ties away from zero
  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic out_item_t next_drive(in_item_t smp);
    longint    pitch, abs_pitch, avg, err, lim, acc, drv;
    out_item_t res;
    pitch     = longint'(smp.pitch_angle);
    abs_pitch = (pitch < 0) ? -pitch : pitch;
    res       = '0;
    if (abs_pitch > longint'(fall_q)) begin
      integ_q    = 0;
      prev_err_q = 0;
      res.fallen = 1'b1;
      return res;
    end
    avg     = (longint'(smp.rpm_left) + longint'(smp.rpm_right)) * 2048;
    filt_q  = div_near(3 * avg + 7 * filt_q, 10);
    err     = longint'(smp.target_speed) - div_near(filt_q, 4096);
    lim     = longint'(ilim_q) * 100;
    integ_q = integ_q + err;
    if (integ_q >= lim) integ_q = lim;
    if (integ_q <= -lim) integ_q = -lim;
    acc = longint'(kp_q) * err * 100 + longint'(ki_q) * integ_q
        + longint'(kd_q) * (err - prev_err_q) * 10000;
    drv = -div_near(acc, 25600);
    if (drv > 64'sd2147483647) drv = 64'sd2147483647;
    if (drv < -64'sd2147483648) drv = -64'sd2147483648;
    prev_err_q      = err;
    res.drive_value = drv[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= KpReset;
      ki_q       <= KiReset;
      kd_q       <= KdReset;
      ilim_q     <= IlimReset;
      fall_q     <= FallReset;
      filt_q     <= 0;
      integ_q    <= 0;
      prev_err_q <= 0;
      fails      <= 0;
      drive_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_KP:   kp_q   = cfg_data_i;
          REG_KI:   ki_q   = cfg_data_i;
          REG_KD:   kd_q   = cfg_data_i;
          REG_ILIM: ilim_q = cfg_data_i[14:0];
          REG_FALL: fall_q = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) drive_fifo.push_back(next_drive(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (drive_fifo.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", out_data_i);
          fails <= fails + 1;
        end else begin
          out_item_t want;
          want = drive_fifo.pop_front();
          if (want.drive_value !== out_data_i.drive_value ||
              want.fallen !== out_data_i.fallen) begin
            if (fails < 10)
              $display("mismatch: drive exp %0d act %0d, fallen exp %b act %b",
                       want.drive_value, out_data_i.drive_value,
                       want.fallen, out_data_i.fallen);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_wheel_speed_pid_filtered_core.sv
// testbench top: clock, reset, sample stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module tb_wheel_speed_pid_filtered_core;
  import wspf_pkg::*;

  localparam longint CycleLimit = 3000000;
  localparam int     HoldCycles = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  int                  fail_count, pending;
  longint              cycles = 0;
  // quiet: no idling on either side; hold_req: receiver holds off for a long stretch
  bit                  quiet = 0;
  bit                  hold_req = 0;
  int unsigned         fall_now = FallReset;

  always #5 clk_i = ~clk_i;

  wheel_speed_pid_filtered_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  wspf_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches and one long hold-off counted here
  always @(negedge clk_i) begin
    int held;
    if (hold_req) begin
      out_stall_i = 1'b1;
      for (held = 0; held < HoldCycles; held++) @(negedge clk_i);
      hold_req = 0;
    end
    out_stall_i = quiet ? 1'b0 : ($urandom_range(0, 99) < 14);
  end

  task automatic cfg_write(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    if (idx == REG_FALL) fall_now = val[14:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // offer one sample, hold it until accepted, then maybe leave a gap
  task automatic send_sample(in_item_t smp);
    bit taken;
    in_valid_i = 1'b1;
    in_data_i  = smp;
    taken      = 1'b0;
    while (!taken) begin
      taken = !in_stall_o;
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
    if (!quiet)
      while ($urandom_range(0, 99) < 14) @(negedge clk_i);
  endtask

  task automatic send_fields(logic [15:0] p, logic [15:0] l, logic [15:0] r, logic [15:0] t);
    in_item_t smp;
    smp.pitch_angle  = p;
    smp.rpm_left     = l;
    smp.rpm_right    = r;
    smp.target_speed = t;
    send_sample(smp);
  endtask

  function automatic logic [15:0] rand_speed();
    if ($urandom_range(0, 99) < 60) return 16'($signed($urandom_range(0, 4000)) - 2000);
    return 16'($urandom());
  endfunction

  // mostly upright samples so the integral and derivative get exercised
  task automatic send_random();
    logic [15:0] p;
    if ($urandom_range(0, 99) < 85)
      p = 16'($signed($urandom_range(0, 2 * fall_now)) - $signed(fall_now));
    else
      p = 16'($urandom());
    send_fields(p, rand_speed(), rand_speed(), rand_speed());
  endtask

  // drain: sender pauses until every expected transaction has arrived
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                           logic [14:0] ilim, logic [14:0] fall);
    cfg_write(REG_KP, kp);
    cfg_write(REG_KI, ki);
    cfg_write(REG_KD, kd);
    cfg_write(REG_ILIM, {1'b0, ilim});
    cfg_write(REG_FALL, {1'b0, fall});
  endtask

  initial begin
    int ph, n;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset gains, field extremes, fall boundary, fallen clears state
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h0000, 16'h7fff, 16'h7fff, 16'h8000);
    send_fields(16'h0000, 16'h8000, 16'h8000, 16'h7fff);
    send_fields(16'h0000, 16'h7fff, 16'h8000, 16'h0000);
    send_fields(16'd15360, 16'h0100, 16'h0100, 16'h0200);
    send_fields(16'd15361, 16'h0100, 16'h0100, 16'h0200);
    send_fields(-16'sd15360, 16'h0010, 16'hfff0, 16'h7fff);
    send_fields(-16'sd15361, 16'h0010, 16'hfff0, 16'h7fff);
    send_fields(16'h8000, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h7fff, 16'h5555, 16'haaaa, 16'h5555);
    for (n = 0; n < 5; n++) send_fields(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    drain();
    // largest gains: drive saturates both ways, integral clamps at full limit
    set_gains(16'hffff, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
    send_fields(16'h0000, 16'h8000, 16'h8000, 16'h7fff);
    send_fields(16'h0000, 16'h7fff, 16'h7fff, 16'h8000);
    send_fields(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    drain();
    // zero integral limit, zero fall limit
    set_gains(16'h0100, 16'h0100, 16'h0000, 15'h0000, 15'h0000);
    send_fields(16'h0000, 16'h0040, 16'h0040, 16'h0400);
    send_fields(16'h0001, 16'h0040, 16'h0040, 16'h0400);
    send_fields(16'hffff, 16'h0040, 16'h0040, 16'h0400);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(KpReset, KiReset, KdReset, IlimReset, FallReset);
        1: set_gains(16'hffff, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
        2: set_gains(16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        3: set_gains(16'h0400, 16'h0200, 16'h0080, 15'h0000, 15'h4000);
        4: set_gains(16'h0533, 16'h014d, 16'h0010, 15'd10, 15'd15360);
        default: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           15'($urandom_range(0, 2000)), 15'($urandom()));
      endcase
      quiet = (ph == 4);
      for (n = 0; n < 180; n++) begin
        if (ph == 1 && n == 20) hold_req = 1;
        send_random();
      end
      drain();
    end

    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
